[rtl/core/pha_pkg.sv]
`default_nettype none

package pha_pkg;

    // Extent table geometry
    localparam int SLOTS   = 32;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int SPARE_W = 6;

    // Address and size widths
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 32;
    localparam int PAGE_SH = 12;
    localparam int PAGE_W  = ADDR_W - PAGE_SH;   // 36-bit page numbers and counts
    localparam int NEED_W  = LEN_W - PAGE_SH + 1; // rounded-up page count of a request

    // Request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_MISALIGN = 2'd3;

    typedef struct packed {
        logic [PAGE_W-1:0] base_page;
        logic [PAGE_W-1:0] pages;
    } t_extent;

endpackage

`default_nettype wire

[rtl/core/page_hole_allocator.sv]
`default_nettype none

// First-fit free-extent allocator, 4 KiB pages, up to 32 extents in address order.
//
// Request channel: an item is taken at a rising edge with start high and busy
// low. i_action selects allocate or free; i_base_address is used only on free;
// i_length_bytes is rounded up to whole pages on allocate and must be page
// aligned on free.
// Result channel: o_result_valid is high for exactly one cycle with o_status,
// o_granted_address and o_spare_slots. The receiver cannot stall it; a result
// is never held back and busy drops in the same cycle it is shown, so the next
// item can be taken while the result is on the ports.
// Walk: the extent list is walked one slot per cycle through the extent
// memory's registered read (the next address is the link read in the previous
// cycle). A request that needs neither walk nor insert answers from idle; a walk
// ends on the extent that settles it, then S_INS writes an inserted extent and
// S_LINK rewrites a predecessor link when one must be rewritten.
// Reset (synchronous, active low) empties the table at once: only the valid bits,
// head pointer, used count, state and result valid clear; memory contents stay.

module page_hole_allocator
    import pha_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_action,
    input  wire logic [ADDR_W-1:0] i_base_address,
    input  wire logic [LEN_W-1:0]  i_length_bytes,
    output logic                   o_result_valid,
    output logic      [1:0]        o_status,
    output logic      [ADDR_W-1:0] o_granted_address,
    output logic      [SPARE_W-1:0] o_spare_slots
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_LINK = 2'd3;

    // Control state
    logic [1:0]        r_state, n_state;
    logic [SLOTS-1:0]  r_valid, n_valid;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_used, n_used;
    logic              r_out_valid, n_out_valid;

    // Per-request working registers
    logic              r_action, n_action;
    logic [PAGE_W-1:0] r_bp, n_bp;
    logic [NEED_W-1:0] r_np, n_np;
    logic [SLOT_W-1:0] r_k, n_k;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_prev, n_prev;
    logic [SLOT_W-1:0] r_ph, n_ph;
    logic [SLOT_W-1:0] r_ph_link, n_ph_link;
    logic [SLOT_W-1:0] r_ins_slot, n_ins_slot;
    logic              r_head_gt, n_head_gt;
    logic              r_stopped, n_stopped;

    // Result registers
    logic [1:0]         r_status, n_status;
    logic [ADDR_W-1:0]  r_grant, n_grant;
    logic [SPARE_W-1:0] r_spare, n_spare;

    // Memory ports
    logic              dat_we, link_we;
    logic [SLOT_W-1:0] dat_waddr, link_waddr, rd_addr;
    t_extent           dat_wdata, dat_rdata;
    logic [SLOT_W-1:0] link_wdata, link_rdata;
    logic [SLOT_W-1:0] free_slot;

    // Datapath terms
    logic              accept, misaligned, last;
    logic [PAGE_W:0]   end_sum, grow_sum;
    logic [PAGE_W-1:0] np_ext, new_pages;
    logic [PAGE_W-1:0] sat_pages;

    pha_ram #(
        .DEPTH (SLOTS),
        .WIDTH ($bits(t_extent))
    ) u_extent_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (dat_wdata),
        .i_raddr (rd_addr),
        .o_rdata (dat_rdata)
    );

    pha_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SLOT_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    pha_slot_pick u_slot_pick (
        .i_valid (r_valid),
        .o_slot  (free_slot)
    );

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign misaligned = (i_base_address[PAGE_SH-1:0] != '0)
                     || (i_length_bytes[PAGE_SH-1:0] != '0);

    // Walk terms on the entry that the memories return this cycle
    assign np_ext    = PAGE_W'(r_np);
    assign end_sum   = {1'b0, dat_rdata.base_page} + {1'b0, dat_rdata.pages};
    assign grow_sum  = {1'b0, dat_rdata.pages} + {1'b0, np_ext};
    assign sat_pages = grow_sum[PAGE_W] ? '1 : grow_sum[PAGE_W-1:0];
    assign new_pages = dat_rdata.pages - np_ext;
    assign last      = (CNT_W'(r_k) + CNT_W'(1)) == r_used;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_head      = r_head;
        n_used      = r_used;
        n_out_valid = 1'b0;
        n_action    = r_action;
        n_bp        = r_bp;
        n_np        = r_np;
        n_k         = r_k;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_ph        = r_ph;
        n_ph_link   = r_ph_link;
        n_ins_slot  = r_ins_slot;
        n_head_gt   = r_head_gt;
        n_stopped   = r_stopped;
        n_status    = r_status;
        n_grant     = r_grant;
        rd_addr     = r_cur;
        dat_we      = 1'b0;
        dat_waddr   = r_cur;
        dat_wdata   = dat_rdata;
        link_we     = 1'b0;
        link_waddr  = r_prev;
        link_wdata  = link_rdata;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_action  = i_action;
                    n_bp      = i_base_address[ADDR_W-1:PAGE_SH];
                    n_k       = '0;
                    n_cur     = r_head;
                    n_prev    = '0;
                    n_ph      = r_head;
                    n_stopped = 1'b0;
                    n_grant   = '0;
                    n_status  = ST_OK;
                    rd_addr   = r_head;
                    if (i_action == ACT_FREE) begin
                        n_np = NEED_W'(i_length_bytes[LEN_W-1:PAGE_SH]);
                        if (misaligned) begin
                            n_status    = ST_MISALIGN;
                            n_out_valid = 1'b1;
                        end else if (i_length_bytes[LEN_W-1:PAGE_SH] == '0) begin
                            n_out_valid = 1'b1;
                        end else if (r_used == '0) begin
                            n_head_gt = 1'b1;
                            n_state   = S_INS;
                        end else begin
                            n_state = S_WALK;
                        end
                    end else begin
                        // Round up to whole pages
                        n_np = {1'b0, i_length_bytes[LEN_W-1:PAGE_SH]}
                             + NEED_W'(i_length_bytes[PAGE_SH-1:0] != '0);
                        if (r_used == '0) begin
                            n_status    = ST_NO_FIT;
                            n_out_valid = 1'b1;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                end
            end

            S_WALK: begin
                if (r_action == ACT_FREE) begin
                    // Track the insertion point on the way
                    if (r_k == '0) begin
                        n_head_gt = dat_rdata.base_page > r_bp;
                        n_ph      = r_cur;
                        n_ph_link = link_rdata;
                    end else if (!r_stopped && dat_rdata.base_page < r_bp) begin
                        n_ph      = r_cur;
                        n_ph_link = link_rdata;
                    end else begin
                        n_stopped = 1'b1;
                    end

                    if (end_sum == {1'b0, r_bp}) begin
                        // Grow the extent that ends at the freed base
                        dat_we          = 1'b1;
                        dat_wdata.pages = sat_pages;
                        n_out_valid     = 1'b1;
                        n_state         = S_IDLE;
                    end else if (last) begin
                        if (r_used == CNT_W'(SLOTS)) begin
                            n_status    = ST_FULL;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end else begin
                            n_state = S_INS;
                        end
                    end else begin
                        rd_addr = link_rdata;
                        n_cur   = link_rdata;
                        n_k     = r_k + SLOT_W'(1);
                    end
                end else begin
                    if (dat_rdata.pages >= np_ext) begin
                        // First fit: hand out the base, advance and shrink
                        dat_we              = 1'b1;
                        dat_wdata.pages     = new_pages;
                        dat_wdata.base_page = dat_rdata.base_page + np_ext;
                        n_grant             = {dat_rdata.base_page, {PAGE_SH{1'b0}}};
                        n_out_valid         = 1'b1;
                        n_state             = S_IDLE;
                        if (new_pages == '0) begin
                            // Release the emptied slot and unlink it
                            n_valid[r_cur] = 1'b0;
                            n_used         = r_used - CNT_W'(1);
                            if (r_k == '0) begin
                                n_head = link_rdata;
                            end else begin
                                link_we    = 1'b1;
                                link_waddr = r_prev;
                                link_wdata = link_rdata;
                            end
                        end
                    end else if (last) begin
                        n_status    = ST_NO_FIT;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_prev  = r_cur;
                        rd_addr = link_rdata;
                        n_cur   = link_rdata;
                        n_k     = r_k + SLOT_W'(1);
                    end
                end
            end

            S_INS: begin
                dat_we              = 1'b1;
                dat_waddr           = free_slot;
                dat_wdata.base_page = r_bp;
                dat_wdata.pages     = np_ext;
                link_we             = 1'b1;
                link_waddr          = free_slot;
                link_wdata          = r_head_gt ? r_head : r_ph_link;
                n_valid[free_slot]  = 1'b1;
                n_used              = r_used + CNT_W'(1);
                if (r_head_gt) begin
                    n_head      = free_slot;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_ins_slot = free_slot;
                    n_state    = S_LINK;
                end
            end

            S_LINK: begin
                // Hook the new extent behind its predecessor
                link_we     = 1'b1;
                link_waddr  = r_ph;
                link_wdata  = r_ins_slot;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_spare = SPARE_W'(CNT_W'(SLOTS) - n_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_head      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_head      <= n_head;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_bp       <= n_bp;
        r_np       <= n_np;
        r_k        <= n_k;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_ph       <= n_ph;
        r_ph_link  <= n_ph_link;
        r_ins_slot <= n_ins_slot;
        r_head_gt  <= n_head_gt;
        r_stopped  <= n_stopped;
        r_status   <= n_status;
        r_grant    <= n_grant;
        r_spare    <= n_spare;
    end

    assign o_result_valid    = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_grant;
    assign o_spare_slots     = r_spare;

endmodule

`default_nettype wire

[rtl/core/pha_ram.sv]
`default_nettype none

module pha_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/pha_slot_pick.sv]
`default_nettype none

module pha_slot_pick
    import pha_pkg::*;
(
    input  wire logic [SLOTS-1:0]  i_valid,
    output logic      [SLOT_W-1:0] o_slot
);

    // Lowest unused slot; scan from the top so the lowest index wins
    always_comb begin
        o_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!i_valid[i]) begin
                o_slot = SLOT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/pha_checker.sv]
`default_nettype none

module pha_checker
    import pha_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_result_valid,
    input wire logic [1:0]         o_status,
    input wire logic [ADDR_W-1:0]  o_granted_address,
    input wire logic [SPARE_W-1:0] o_spare_slots
);

    // An accepted item either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_result_valid)
        else $error("accepted item neither busy nor answered");

    // Busy drops only when a result is shown
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy dropped without a result");

    // No grant unless the status is ok, and grants are page aligned
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_status != ST_OK |-> o_granted_address == '0)
        else $error("grant on a failed request");

    a_grant_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_granted_address[PAGE_SH-1:0] == '0)
        else $error("grant not page aligned");

    // Spare count never exceeds the table size
    a_spare_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_spare_slots <= SPARE_W'(SLOTS))
        else $error("spare slot count out of range");

endmodule

bind page_hole_allocator pha_checker u_pha_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_result_valid    (o_result_valid),
    .o_status          (o_status),
    .o_granted_address (o_granted_address),
    .o_spare_slots     (o_spare_slots)
);

`default_nettype wire

[tb/page_hole_checker.sv]
`default_nettype none

// Watch the request and result channels of the page hole allocator, keep a
// private copy of the free-extent table, and compare every result with the
// reply predicted for its request.
module page_hole_checker
    import pha_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic               i_action,
    input  wire logic [ADDR_W-1:0]  i_base_address,
    input  wire logic [LEN_W-1:0]   i_length_bytes,
    input  wire logic               i_result_valid,
    input  wire logic [1:0]         i_status,
    input  wire logic [ADDR_W-1:0]  i_granted_address,
    input  wire logic [SPARE_W-1:0] i_spare_slots,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_grants,
    output int                      o_no_fits,
    output int                      o_full_hits
);

    localparam logic [63:0]       PAGE_ROUND = 64'hfff;
    localparam logic [PAGE_W-1:0] PAGES_MAX  = {PAGE_W{1'b1}};

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  grant;
        logic [SPARE_W-1:0] spare;
    } t_reply;

    t_reply awaited_replies[$];

    // Extent table copy
    logic [PAGE_W-1:0] base_pg   [SLOTS];
    logic [PAGE_W-1:0] size_pg   [SLOTS];
    bit                in_use    [SLOTS];
    logic [SLOT_W-1:0] next_slot [SLOTS];
    logic [SLOT_W-1:0] first_slot;
    int unsigned       used;

    function automatic t_reply make_reply(logic [1:0] status, logic [ADDR_W-1:0] grant);
        t_reply r;
        r.status = status;
        r.grant  = grant;
        r.spare  = SPARE_W'(SLOTS - used);
        return r;
    endfunction

    function automatic t_reply free_extent(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
        logic [63:0]       np;
        logic [63:0]       bp;
        logic [63:0]       sum;
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] ph;
        logic [SLOT_W-1:0] s;
        int                k;
        int                idx;
        if (addr[PAGE_SH-1:0] != '0 || len[PAGE_SH-1:0] != '0)
            return make_reply(ST_MISALIGN, '0);
        np = 64'(len >> PAGE_SH);
        if (np == 0)
            return make_reply(ST_OK, '0);
        bp = 64'(addr >> PAGE_SH);

        // grow the first extent, in address order, that ends at the freed base
        p = first_slot;
        for (k = 0; k < int'(used); k++) begin
            if (64'(base_pg[p]) + 64'(size_pg[p]) == bp) begin
                sum = 64'(size_pg[p]) + np;
                size_pg[p] = (sum > 64'(PAGES_MAX)) ? PAGES_MAX : sum[PAGE_W-1:0];
                return make_reply(ST_OK, '0);
            end
            p = next_slot[p];
        end

        if (used >= SLOTS)
            return make_reply(ST_FULL, '0);
        idx = 0;
        while (idx < SLOTS && in_use[idx])
            idx++;
        if (idx >= SLOTS)
            return make_reply(ST_FULL, '0);
        s = SLOT_W'(idx);

        in_use[s]  = 1'b1;
        base_pg[s] = bp[PAGE_W-1:0];
        size_pg[s] = np[PAGE_W-1:0];
        if (used == 0 || base_pg[first_slot] > bp[PAGE_W-1:0]) begin
            next_slot[s] = first_slot;
            first_slot   = s;
        end else begin
            // equal base with the head lands after it
            ph = first_slot;
            k  = 1;
            while (k < int'(used) && base_pg[next_slot[ph]] < bp[PAGE_W-1:0]) begin
                ph = next_slot[ph];
                k++;
            end
            next_slot[s]  = next_slot[ph];
            next_slot[ph] = s;
        end
        used++;
        return make_reply(ST_OK, '0);
    endfunction

    function automatic t_reply grant_pages(logic [LEN_W-1:0] len);
        logic [63:0]       need;
        logic [ADDR_W-1:0] grant;
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] prev;
        int                k;
        need = (64'(len) + PAGE_ROUND) >> PAGE_SH;
        p    = first_slot;
        prev = '0;
        for (k = 0; k < int'(used); k++) begin
            if (64'(size_pg[p]) >= need)
                break;
            prev = p;
            p    = next_slot[p];
        end
        if (k >= int'(used))
            return make_reply(ST_NO_FIT, '0);

        grant      = {base_pg[p], {PAGE_SH{1'b0}}};
        size_pg[p] = size_pg[p] - need[PAGE_W-1:0];
        base_pg[p] = base_pg[p] + need[PAGE_W-1:0];   // wraps within the page space
        if (size_pg[p] == '0) begin
            if (k == 0)
                first_slot = next_slot[p];
            else
                next_slot[prev] = next_slot[p];
            in_use[p] = 1'b0;
            used--;
        end
        return make_reply(ST_OK, grant);
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            awaited_replies.delete();
            for (int i = 0; i < SLOTS; i++) begin
                base_pg[i]   = '0;
                size_pg[i]   = '0;
                in_use[i]    = 1'b0;
                next_slot[i] = '0;
            end
            first_slot   = '0;
            used         = 0;
            o_fail_count = 0;
            o_checked    = 0;
            o_grants     = 0;
            o_no_fits    = 0;
            o_full_hits  = 0;
        end else begin
            // retire the result shown in this cycle before taking a new item
            if (i_result_valid) begin
                got = '{i_status, i_granted_address, i_spare_slots};
                if (awaited_replies.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result status %h grant %h spare %0d",
                             $time, got.status, got.grant, got.spare);
                end else begin
                    want = awaited_replies.pop_front();
                    o_checked++;
                    if (got.status !== want.status) begin
                        o_fail_count++;
                        $display("%0t: status expected %h actual %h",
                                 $time, want.status, got.status);
                    end
                    if (got.grant !== want.grant) begin
                        o_fail_count++;
                        $display("%0t: granted_address expected %h actual %h",
                                 $time, want.grant, got.grant);
                    end
                    if (got.spare !== want.spare) begin
                        o_fail_count++;
                        $display("%0t: spare_slots expected %0d actual %0d",
                                 $time, want.spare, got.spare);
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_action == ACT_FREE)
                    want = free_extent(i_base_address, i_length_bytes);
                else
                    want = grant_pages(i_length_bytes);
                if (want.status == ST_NO_FIT)
                    o_no_fits++;
                if (want.status == ST_FULL)
                    o_full_hits++;
                if (i_action == ACT_ALLOC && want.status == ST_OK)
                    o_grants++;
                awaited_replies.push_back(want);
            end
        end
        o_pending = awaited_replies.size();
    end

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
    import pha_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 800;
    localparam int BLOCK_ITEMS  = 100;   // items per fill or drain stretch
    localparam int CALM_ITEMS   = 120;   // closing items sent with no idling
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // Address regions used by the random part, lowest first so that first fit
    // chews through the small window before the growth region.
    localparam logic [ADDR_W-1:0] GROW_REGION = 48'h0000_8000_0000;
    localparam logic [ADDR_W-1:0] PAGE_MASK   = 48'hFFFF_FFFF_F000;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               i_action       = ACT_ALLOC;
    logic [ADDR_W-1:0]  i_base_address = '0;
    logic [LEN_W-1:0]   i_length_bytes = '0;
    wire logic          busy;
    wire logic          o_result_valid;
    wire logic [1:0]    o_status;
    wire logic [ADDR_W-1:0]  o_granted_address;
    wire logic [SPARE_W-1:0] o_spare_slots;

    int fail_count;
    int pending;
    int checked;
    int grants;
    int no_fits;
    int full_hits;
    int cycles = 0;
    int sent   = 0;
    logic [ADDR_W-1:0] grow_cursor = GROW_REGION;

    always #2 i_clk = ~i_clk;

    page_hole_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_base_address    (i_base_address),
        .i_length_bytes    (i_length_bytes),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_spare_slots     (o_spare_slots)
    );

    page_hole_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_action          (i_action),
        .i_base_address    (i_base_address),
        .i_length_bytes    (i_length_bytes),
        .i_result_valid    (o_result_valid),
        .i_status          (o_status),
        .i_granted_address (o_granted_address),
        .i_spare_slots     (o_spare_slots),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_grants          (grants),
        .o_no_fits         (no_fits),
        .o_full_hits       (full_hits)
    );

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, pending);
            $display("[page_hole_allocator] ERROR");
            $finish;
        end
    end

    // Present one item at the falling edge and hold it until the block takes it.
    // Start stays high when the caller sends the next item right away.
    task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len);
        @(negedge i_clk);
        start          <= 1'b1;
        i_action       <= act;
        i_base_address <= addr;
        i_length_bytes <= len;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sent++;
    endtask

    // Drop start for a number of cycles.
    task automatic idle(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Hold off the sender until every result owed has come back.
    task automatic settle();
        idle(1);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // One random request. A fill stretch leans on frees, a drain stretch on
    // allocations, so the table keeps swinging between empty and full.
    task automatic send_random(input bit fill);
        int                kind;
        int                pick;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (kind < (fill ? 65 : 30)) begin
            if (pick < 35) begin
                // extend the region right behind the last free: grows an extent
                len = LEN_W'($urandom_range(1, 8)) << PAGE_SH;
                if ($urandom_range(0, 15) == 0)
                    grow_cursor = GROW_REGION + (ADDR_W'($urandom_range(0, 4095)) << PAGE_SH);
                addr = grow_cursor;
                grow_cursor = grow_cursor + ADDR_W'(len);
            end else if (pick < 78) begin
                // small holes in a low window: mostly new extents
                addr = ADDR_W'($urandom_range(0, 1023)) << PAGE_SH;
                len  = LEN_W'($urandom_range(1, 16)) << PAGE_SH;
            end else if (pick < 84) begin
                // aligned anywhere in the address space
                addr = ADDR_W'({$urandom, $urandom}) & PAGE_MASK;
                len  = ($urandom_range(0, 1) == 0) ? ($urandom & 32'hFFFF_F000)
                                                   : (LEN_W'($urandom_range(1, 4)) << PAGE_SH);
            end else if (pick < 93) begin
                // raw random: almost always misaligned
                addr = ADDR_W'({$urandom, $urandom});
                len  = $urandom;
            end else begin
                addr = ADDR_W'({$urandom, $urandom});
                len  = '0;
            end
            send_item(ACT_FREE, addr, len);
        end else begin
            addr = ADDR_W'({$urandom, $urandom});   // ignored on allocate
            if (pick < 60)
                len = LEN_W'($urandom_range(1, 32'h8000));
            else if (pick < 75)
                len = LEN_W'($urandom_range(1, 16)) << PAGE_SH;
            else if (pick < 85)
                len = '0;
            else
                len = $urandom;
            send_item(ACT_ALLOC, addr, len);
        end
    endtask

    initial begin
        // Hold reset, then release it at a falling edge.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, wrap of the page space, alignment,
        // growth, ordering and release at the head and further down.
        send_item(ACT_ALLOC, '0, '0);
        send_item(ACT_ALLOC, '1, 32'h0000_0001);
        send_item(ACT_FREE,  48'hFFFF_FFFF_F000, 32'h0001_0000);
        send_item(ACT_ALLOC, '0, 32'h0000_1000);        // top page, base wraps
        send_item(ACT_ALLOC, '0, 32'h0000_0001);        // rounds up to a page
        send_item(ACT_ALLOC, '0, 32'h0000_E000);        // empties the extent
        send_item(ACT_FREE,  48'h0000_0000_1001, 32'h0000_1000);
        send_item(ACT_FREE,  48'h0000_0000_2000, 32'h0000_1800);
        send_item(ACT_FREE,  '1, '1);
        send_item(ACT_FREE,  48'h0000_0000_5000, '0);
        send_item(ACT_FREE,  48'h0000_0001_0000, 32'h0000_4000);
        send_item(ACT_FREE,  48'h0000_0001_4000, 32'h0000_2000);   // grows
        send_item(ACT_FREE,  48'h0000_0001_0000, 32'h0000_1000);   // same base as head
        send_item(ACT_FREE,  48'h0000_0000_8000, 32'h0000_1000);   // new head
        send_item(ACT_FREE,  48'h0000_0000_C000, 32'h0000_1000);   // mid-list insert
        send_item(ACT_FREE,  48'h8000_0000_0000, 32'hFFFF_F000);   // largest length
        send_item(ACT_ALLOC, '0, '0);                    // head base, no change
        send_item(ACT_ALLOC, '0, 32'h0000_2000);
        send_item(ACT_ALLOC, '0, 32'h0000_1000);         // releases the head
        send_item(ACT_ALLOC, '0, 32'h0000_3000);
        send_item(ACT_ALLOC, '0, 32'hFFFF_FFFF);         // one page too many
        send_item(ACT_ALLOC, '0, 32'hFFFF_F000);         // releases a later extent
        settle();

        // Random part: alternate fill and drain stretches, bursty idling,
        // a full stop halfway, and a closing stretch at full rate.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                settle();
            send_random(((n / BLOCK_ITEMS) % 2) == 0);
            if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                idle($urandom_range(1, 17));
        end

        // Drain: nothing owed, then let any trailing work finish.
        settle();
        idle(DRAIN_CYCLES);

        $display("%0d requests sent, %0d results checked in %0d cycles",
                 sent, checked, cycles);
        $display("%0d grants, %0d no-fit refusals, %0d table-full refusals",
                 grants, no_fits, full_hits);
        if (fail_count == 0) begin
            $display("[page_hole_allocator] OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[page_hole_allocator] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
